>>> hw/rtl/hse_pkg.sv
// Package for the Hall set enumerator: fixed widths, register and status codes,
// and the command and status structs that join the controller to the datapath.
// No dependencies.
package hse_pkg;

  localparam int DEF_MAX_ELEMENTS = 1024;
  localparam int DEF_MAX_DEGREE   = 8;
  localparam int DEF_MAX_LETTERS  = 16;

  localparam int OUT_IDX_W  = 10;
  localparam int OUT_DEG_W  = 4;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int ALPHA_W    = 5;
  localparam int MAXDEG_W   = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEGREE     = 2'd1;

  localparam logic [STATUS_W-1:0] ST_ELEMENT  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FINISHED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

  localparam logic [ALPHA_W-1:0]  ALPHA_RESET  = 5'd2;
  localparam logic [MAXDEG_W-1:0] MAXDEG_RESET = 4'd4;

  typedef struct packed {
    logic                restart;
    logic                emit_letter;
    logic                emit_pair;
    logic                emit_end;
    logic [STATUS_W-1:0] end_code;
    logic                emit_sticky;
    logic                close_degree;
    logic                enter_next;
    logic                load_hi_i;
    logic                load_hi_j;
    logic                next_split;
    logic                load_lcur;
    logic                place;
    logic                next_left;
    logic                issue_read;
    logic                next_right;
  } cmd_t;

  typedef struct packed {
    logic fin_nz;
    logic deg_le1;
    logic letter_more;
    logic store_full;
    logic deg_done;
    logic next_over;
    logic li_done;
    logic split_more;
    logic rj_done;
    logic hall_ok;
    logic out_free;
  } stat_t;

endpackage

>>> hw/rtl/hse_ctrl.sv
// Controller state machine of the Hall set enumerator.
// Sequences the candidate scan and issues commands to hse_dp; uses hse_pkg.
module hse_ctrl import hse_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  logic  restart,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_BEGIN = 4'd1;
  localparam logic [3:0] S_LET   = 4'd2;
  localparam logic [3:0] S_DEG   = 4'd3;
  localparam logic [3:0] S_HI    = 4'd4;
  localparam logic [3:0] S_CHKI  = 4'd5;
  localparam logic [3:0] S_LCUR  = 4'd6;
  localparam logic [3:0] S_PLACE = 4'd7;
  localparam logic [3:0] S_HJ    = 4'd8;
  localparam logic [3:0] S_CHKJ  = 4'd9;
  localparam logic [3:0] S_CMP   = 4'd10;

  logic [3:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.restart = restart;
          state_next  = S_BEGIN;
        end
      end
      S_BEGIN: begin
        if (stat.fin_nz) begin
          if (stat.out_free) begin
            cmd.emit_sticky = 1'b1;
            state_next      = S_IDLE;
          end
        end else if (stat.deg_le1) begin
          state_next = S_LET;
        end else begin
          state_next = S_DEG;
        end
      end
      S_LET: begin
        if (stat.letter_more) begin
          if (stat.out_free) begin
            if (stat.store_full) begin
              cmd.emit_end = 1'b1;
              cmd.end_code = ST_FULL;
            end else begin
              cmd.emit_letter = 1'b1;
            end
            state_next = S_IDLE;
          end
        end else if (stat.next_over) begin
          if (stat.out_free) begin
            cmd.close_degree = 1'b1;
            cmd.emit_end     = 1'b1;
            cmd.end_code     = ST_FINISHED;
            state_next       = S_IDLE;
          end
        end else begin
          cmd.close_degree = 1'b1;
          cmd.enter_next   = 1'b1;
          state_next       = S_PLACE;
        end
      end
      S_DEG: begin
        if (stat.deg_done) begin
          if (stat.next_over) begin
            if (stat.out_free) begin
              cmd.close_degree = 1'b1;
              cmd.emit_end     = 1'b1;
              cmd.end_code     = ST_FINISHED;
              state_next       = S_IDLE;
            end
          end else begin
            cmd.close_degree = 1'b1;
            cmd.enter_next   = 1'b1;
            state_next       = S_PLACE;
          end
        end else begin
          state_next = S_HI;
        end
      end
      S_HI: begin
        cmd.load_hi_i = 1'b1;
        state_next    = S_CHKI;
      end
      S_CHKI: begin
        if (stat.li_done) begin
          cmd.next_split = 1'b1;
          state_next     = stat.split_more ? S_LCUR : S_DEG;
        end else begin
          state_next = S_HJ;
        end
      end
      S_LCUR: begin
        cmd.load_lcur = 1'b1;
        state_next    = S_PLACE;
      end
      S_PLACE: begin
        cmd.place  = 1'b1;
        state_next = S_HI;
      end
      S_HJ: begin
        cmd.load_hi_j = 1'b1;
        state_next    = S_CHKJ;
      end
      S_CHKJ: begin
        if (stat.rj_done) begin
          cmd.next_left = 1'b1;
          state_next    = S_PLACE;
        end else begin
          cmd.issue_read = 1'b1;
          state_next     = S_CMP;
        end
      end
      S_CMP: begin
        if (stat.hall_ok) begin
          if (stat.out_free) begin
            if (stat.store_full) begin
              cmd.emit_end = 1'b1;
              cmd.end_code = ST_FULL;
            end else begin
              cmd.emit_pair = 1'b1;
            end
            state_next = S_IDLE;
          end
        end else begin
          cmd.next_right = 1'b1;
          state_next     = S_CHKJ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/hse_dp.sv
// Datapath of the Hall set enumerator: configuration registers, cursors, the
// degree start table, the left parent memory and the result register; uses hse_pkg.
module hse_dp import hse_pkg::*; #(
  parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
  parameter int MAX_DEGREE   = DEF_MAX_DEGREE,
  parameter int MAX_LETTERS  = DEF_MAX_LETTERS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_IDX_W-1:0]  element_index,
  output logic [OUT_IDX_W-1:0]  left_index,
  output logic [OUT_IDX_W-1:0]  right_index,
  output logic [OUT_DEG_W-1:0]  element_degree,
  output logic [STATUS_W-1:0]   status
);

  localparam int ADDR_W   = $clog2(MAX_ELEMENTS);
  localparam int IDX_W    = $clog2(MAX_ELEMENTS + 1);
  localparam int DS_DEPTH = MAX_DEGREE + 2;
  localparam int DEG_W    = $clog2(DS_DEPTH);
  localparam int EDW      = (DEG_W > MAXDEG_W) ? DEG_W + 1 : MAXDEG_W + 1;
  localparam int CMP_W    = (IDX_W > 8) ? IDX_W : 9;

  logic [ALPHA_W-1:0]  alphabet_width;
  logic [MAXDEG_W-1:0] deg_limit;

  logic [DEG_W-1:0]    cur_deg;
  logic [DEG_W-1:0]    split;
  logic [IDX_W-1:0]    lcur;
  logic [IDX_W-1:0]    rcur;
  logic [IDX_W-1:0]    nfree;
  logic [STATUS_W-1:0] fin;
  logic [IDX_W-1:0]    hi_i;
  logic [IDX_W-1:0]    hi_j;

  logic [IDX_W-1:0]  ds [DS_DEPTH];
  logic [ADDR_W-1:0] lps [MAX_ELEMENTS];
  logic [ADDR_W-1:0] rdata;

  logic [CMP_W-1:0] eff_w;
  logic [EDW-1:0]   eff_deg;
  logic [DEG_W-1:0] ds_addr;
  logic [IDX_W-1:0] ds_rd;
  logic [IDX_W-1:0] lcur_inc;
  logic [IDX_W-1:0] place_val;
  logic             wr_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_width <= ALPHA_RESET;
      deg_limit      <= MAXDEG_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ALPHABET_WIDTH: alphabet_width <= cfg_data[ALPHA_W-1:0];
        CFG_MAX_DEGREE:     deg_limit      <= cfg_data[MAXDEG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    eff_w = CMP_W'(alphabet_width);
    if (alphabet_width == '0) begin
      eff_w = CMP_W'(1);
    end
    if (eff_w > CMP_W'(MAX_LETTERS)) begin
      eff_w = CMP_W'(MAX_LETTERS);
    end
    eff_deg = EDW'(deg_limit);
    if (deg_limit == '0) begin
      eff_deg = EDW'(1);
    end
    if (eff_deg > EDW'(MAX_DEGREE)) begin
      eff_deg = EDW'(MAX_DEGREE);
    end
  end

  always_comb begin
    if (cmd.load_hi_i) begin
      ds_addr = split + DEG_W'(1);
    end else if (cmd.load_lcur) begin
      ds_addr = split;
    end else if (cmd.place) begin
      ds_addr = cur_deg - split;
    end else begin
      ds_addr = cur_deg - split + DEG_W'(1);
    end
    ds_rd     = (ds_addr == DEG_W'(1)) ? IDX_W'(1) : ds[ds_addr];
    lcur_inc  = lcur + IDX_W'(1);
    place_val = (lcur_inc > ds_rd) ? lcur_inc : ds_rd;
  end

  always_comb begin
    stat.fin_nz      = (fin != ST_ELEMENT);
    stat.deg_le1     = (cur_deg <= DEG_W'(1));
    stat.letter_more = (CMP_W'(nfree) <= eff_w);
    stat.store_full  = (nfree >= IDX_W'(MAX_ELEMENTS));
    stat.deg_done    = ({1'b0, split, 1'b0} > (DEG_W + 2)'(cur_deg));
    stat.next_over   = ((EDW'(cur_deg) + EDW'(1)) > eff_deg);
    stat.li_done     = (lcur >= hi_i);
    stat.split_more  = ({1'b0, split + DEG_W'(1), 1'b0} <= (DEG_W + 2)'(cur_deg));
    stat.rj_done     = (rcur >= hi_j) || (rcur >= IDX_W'(MAX_ELEMENTS));
    stat.hall_ok     = (IDX_W'(rdata) <= lcur);
    stat.out_free    = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      cur_deg <= DEG_W'(1);
      split   <= DEG_W'(1);
      lcur    <= '0;
      rcur    <= '0;
      nfree   <= IDX_W'(1);
      fin     <= ST_ELEMENT;
    end else begin
      if (cmd.emit_letter || cmd.emit_pair) begin
        nfree <= nfree + IDX_W'(1);
      end
      if (cmd.emit_end) begin
        fin <= cmd.end_code;
      end
      if (cmd.enter_next) begin
        cur_deg <= cur_deg + DEG_W'(1);
        split   <= DEG_W'(1);
        lcur    <= IDX_W'(1);
      end
      if (cmd.next_split) begin
        split <= split + DEG_W'(1);
      end
      if (cmd.load_lcur) begin
        lcur <= ds_rd;
      end
      if (cmd.next_left) begin
        lcur <= lcur_inc;
      end
      if (cmd.place) begin
        rcur <= place_val;
      end
      if (cmd.emit_pair || cmd.next_right) begin
        rcur <= rcur + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_hi_i) begin
      hi_i <= ds_rd;
    end
    if (cmd.load_hi_j) begin
      hi_j <= ds_rd;
    end
    if (cmd.close_degree) begin
      ds[cur_deg + DEG_W'(1)] <= nfree;
    end
  end

  assign wr_en = cmd.emit_letter || cmd.emit_pair;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lps[nfree[ADDR_W-1:0]] <= cmd.emit_pair ? lcur[ADDR_W-1:0] : '0;
    end
    if (cmd.issue_read) begin
      rdata <= lps[rcur[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_letter || cmd.emit_pair || cmd.emit_end || cmd.emit_sticky) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_letter) begin
      element_index  <= OUT_IDX_W'(nfree);
      left_index     <= '0;
      right_index    <= OUT_IDX_W'(nfree);
      element_degree <= OUT_DEG_W'(1);
      status         <= ST_ELEMENT;
    end else if (cmd.emit_pair) begin
      element_index  <= OUT_IDX_W'(nfree);
      left_index     <= OUT_IDX_W'(lcur);
      right_index    <= OUT_IDX_W'(rcur);
      element_degree <= OUT_DEG_W'(cur_deg);
      status         <= ST_ELEMENT;
    end else if (cmd.emit_end || cmd.emit_sticky) begin
      element_index  <= '0;
      left_index     <= '0;
      right_index    <= '0;
      element_degree <= '0;
      status         <= cmd.emit_end ? cmd.end_code : fin;
    end
  end

`ifndef SYNTHESIS
  a_nfree_bound: assert property (@(posedge clk) disable iff (rst)
    nfree <= IDX_W'(MAX_ELEMENTS))
    else $error("Next free index has passed the store capacity.");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_letter || cmd.emit_pair || cmd.emit_end || cmd.emit_sticky) |-> stat.out_free)
    else $error("A word was produced while the result register was still occupied.");

  a_emit_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.emit_letter, cmd.emit_pair, cmd.emit_end, cmd.emit_sticky}))
    else $error("More than one result was produced in a single cycle.");

  a_pair_hall: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_pair |-> (lcur < rcur) && stat.hall_ok)
    else $error("An emitted pair breaks the Hall ordering condition.");

  a_end_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_ELEMENT) |-> (element_index == '0 && element_degree == '0))
    else $error("An end-of-enumeration word carries a non-zero element.");
`endif

endmodule

>>> hw/rtl/hall_set_enumerator_top.sv
// Hall set enumerator: the block's usage contract.
// An input word on the in channel carries restart: 1 restarts at letter 1, 0 asks for
// the next Hall element. Exactly one result word leaves on the out channel for each
// input word: element_index, left_index, right_index, element_degree and status
// (0 element, 1 finished, 2 store full; the element fields are 0 for 1 and 2).
// The cfg channel writes alphabet_width (index 0) and the degree limit (index 1) and is
// always ready; write it only while the block is idle.
// A letter, an end word found at once or a repeated end word needs no search; a pair
// is searched for by stepping through right candidates, left cursor steps and split or
// degree changes, each right candidate being read from the left parent memory through
// its registered read port.
// One word is in work at a time; in_ready is high only while the controller is idle.
// The result register lets the next word be accepted while a result waits; if the
// receiver stalls, the following result holds its last step until the register frees.
// Reset sets the registers to width 2 and degree 4 and leaves the enumeration as if
// restarted, so a first request without restart returns letter 1. No clearing pass.
module hall_set_enumerator_top import hse_pkg::*; #(
  parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
  parameter int MAX_DEGREE   = DEF_MAX_DEGREE,
  parameter int MAX_LETTERS  = DEF_MAX_LETTERS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  restart,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_IDX_W-1:0]  element_index,
  output logic [OUT_IDX_W-1:0]  left_index,
  output logic [OUT_IDX_W-1:0]  right_index,
  output logic [OUT_DEG_W-1:0]  element_degree,
  output logic [STATUS_W-1:0]   status,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  hse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .restart  (restart),
    .stat     (stat),
    .cmd      (cmd)
  );

  hse_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .MAX_DEGREE   (MAX_DEGREE),
    .MAX_LETTERS  (MAX_LETTERS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .element_index  (element_index),
    .left_index     (left_index),
    .right_index    (right_index),
    .element_degree (element_degree),
    .status         (status)
  );

endmodule

>>> tb/hse_checker.sv
// Checker for the Hall set enumerator: watches the register, request and result channels,
// keeps its own model of the enumeration and compares every result word field by field.
// Depends on hse_pkg for the widths, register indexes and status codes.
`timescale 1ns / 1ps

module hse_checker import hse_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  restart,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [OUT_IDX_W-1:0]  element_index,
  input  logic [OUT_IDX_W-1:0]  left_index,
  input  logic [OUT_IDX_W-1:0]  right_index,
  input  logic [OUT_DEG_W-1:0]  element_degree,
  input  logic [STATUS_W-1:0]   status,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int unsigned           mismatches,
  output int unsigned           words_due
);

  localparam int STORE_DEPTH = DEF_MAX_ELEMENTS;
  localparam int DEG_TOP     = DEF_MAX_DEGREE;
  localparam int LETTER_TOP  = DEF_MAX_LETTERS;
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] idx;
    logic [OUT_IDX_W-1:0] lparent;
    logic [OUT_IDX_W-1:0] rparent;
    logic [OUT_DEG_W-1:0] degree;
    logic [STATUS_W-1:0]  code;
  } hall_word_t;

  logic [ALPHA_W-1:0]   alpha_reg;
  logic [MAXDEG_W-1:0]  maxdeg_reg;
  logic [9:0]           lparent_mem [0:STORE_DEPTH-1];
  logic [10:0]          deg_start [0:DEG_TOP+1];
  logic [3:0]           cur_deg;
  logic [3:0]           split;
  logic [10:0]          lcur;
  logic [10:0]          rcur;
  logic [10:0]          free_idx;
  logic [STATUS_W-1:0]  end_code;
  hall_word_t           hall_words_due [$];
  int unsigned          words_seen;

  function automatic int unsigned letter_count();
    if (alpha_reg == '0) return 1;
    if (alpha_reg > LETTER_TOP) return LETTER_TOP;
    return alpha_reg;
  endfunction

  function automatic int unsigned degree_limit();
    if (maxdeg_reg == '0) return 1;
    if (maxdeg_reg > DEG_TOP) return DEG_TOP;
    return maxdeg_reg;
  endfunction

  function automatic void restart_walk();
    for (int k = 0; k <= DEG_TOP + 1; k++) deg_start[k] = '0;
    deg_start[1] = 11'd1;
    cur_deg  = 4'd1;
    split    = 4'd1;
    lcur     = '0;
    rcur     = '0;
    free_idx = 11'd1;
    end_code = ST_ELEMENT;
  endfunction

  function automatic void first_right();
    logic [10:0] lo;
    lo = deg_start[cur_deg - split];
    rcur = (lcur + 11'd1 > lo) ? lcur + 11'd1 : lo;
  endfunction

  function automatic void open_degree(input logic [3:0] dd);
    cur_deg = dd;
    split   = 4'd1;
    lcur    = deg_start[1];
    first_right();
  endfunction

  function automatic hall_word_t finish_with(input logic [STATUS_W-1:0] code);
    hall_word_t w;
    end_code = code;
    w = '0;
    w.code = code;
    return w;
  endfunction

  function automatic hall_word_t element_word(input int unsigned n, input int unsigned lp,
                                              input int unsigned rp, input int unsigned dg);
    hall_word_t w;
    w.idx     = OUT_IDX_W'(n);
    w.lparent = OUT_IDX_W'(lp);
    w.rparent = OUT_IDX_W'(rp);
    w.degree  = OUT_DEG_W'(dg);
    w.code    = ST_ELEMENT;
    return w;
  endfunction

  function automatic hall_word_t next_element(input logic rs);
    int unsigned d;
    int unsigned e;
    int unsigned i;
    int unsigned j;
    int unsigned n;
    if (rs) restart_walk();
    if (end_code != ST_ELEMENT) return finish_with(end_code);
    while (1'b1) begin
      if (cur_deg <= 1) begin
        if (free_idx <= letter_count()) begin
          n = free_idx;
          if (n >= STORE_DEPTH) return finish_with(ST_FULL);
          lparent_mem[n] = '0;
          free_idx = 11'(n + 1);
          return element_word(n, 0, n, 1);
        end
        deg_start[2] = free_idx;
        if (2 > degree_limit()) return finish_with(ST_FINISHED);
        open_degree(4'd2);
      end else begin
        d = cur_deg;
        e = split;
        if (2 * e > d) begin
          deg_start[d + 1] = free_idx;
          if (d + 1 > degree_limit()) return finish_with(ST_FINISHED);
          open_degree(4'(d + 1));
        end else if (lcur >= deg_start[e + 1]) begin
          split = 4'(e + 1);
          if (2 * (e + 1) <= d) begin
            lcur = deg_start[e + 1];
            first_right();
          end
        end else if (rcur >= deg_start[d - e + 1] || rcur >= STORE_DEPTH) begin
          lcur = lcur + 11'd1;
          first_right();
        end else begin
          i = lcur;
          j = rcur;
          if (lparent_mem[j] <= i) begin
            n = free_idx;
            if (n >= STORE_DEPTH) return finish_with(ST_FULL);
            lparent_mem[n] = 10'(i);
            free_idx = 11'(n + 1);
            rcur = 11'(j + 1);
            return element_word(n, i, j, d);
          end
          rcur = 11'(j + 1);
        end
      end
    end
    return finish_with(ST_FULL);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < PRINT_LIMIT)
      $display("%0t result word %0d: %s is %0d, expected %0d", $time, words_seen, what, got,
               want);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    hall_word_t seen_word;
    hall_word_t due_word;
    if (rst) begin
      alpha_reg  = ALPHA_RESET;
      maxdeg_reg = MAXDEG_RESET;
      restart_walk();
      hall_words_due.delete();
      mismatches = 0;
      words_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ALPHABET_WIDTH) alpha_reg = cfg_data[ALPHA_W-1:0];
        else if (cfg_index == CFG_MAX_DEGREE) maxdeg_reg = cfg_data[MAXDEG_W-1:0];
      end
      if (out_valid && out_ready) begin
        words_seen++;
        seen_word = '{element_index, left_index, right_index, element_degree, status};
        if (hall_words_due.size() == 0) begin
          report_mismatch("unexpected word, status", seen_word.code, 0);
        end else begin
          due_word = hall_words_due.pop_front();
          if (seen_word.idx != due_word.idx)
            report_mismatch("element_index", seen_word.idx, due_word.idx);
          if (seen_word.lparent != due_word.lparent)
            report_mismatch("left_index", seen_word.lparent, due_word.lparent);
          if (seen_word.rparent != due_word.rparent)
            report_mismatch("right_index", seen_word.rparent, due_word.rparent);
          if (seen_word.degree != due_word.degree)
            report_mismatch("element_degree", seen_word.degree, due_word.degree);
          if (seen_word.code != due_word.code)
            report_mismatch("status", seen_word.code, due_word.code);
        end
      end
      if (in_valid && in_ready) hall_words_due = {hall_words_due, next_element(restart)};
    end
    words_due = hall_words_due.size();
  end

endmodule

>>> tb/tb.sv
// Top of the Hall set enumerator testbench: clock, reset, register writes and request
// words under several idling patterns, with the verdict taken from hse_checker.
// Depends on hse_pkg, hall_set_enumerator_top and hse_checker.
`timescale 1ns / 1ps

module tb;
  import hse_pkg::*;

  localparam int WATCHDOG_LIMIT = 50000;
  localparam int RANDOM_WORDS   = 900;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  restart = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [OUT_IDX_W-1:0]  element_index;
  logic [OUT_IDX_W-1:0]  left_index;
  logic [OUT_IDX_W-1:0]  right_index;
  logic [OUT_DEG_W-1:0]  element_degree;
  logic [STATUS_W-1:0]   status;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_ALPHABET_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned mismatches;
  int unsigned words_due;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned words_sent = 0;
  int unsigned quiet_cycles = 0;
  int unsigned idle_plan [4] = '{0, 86, 0, 34};
  int unsigned stall_plan [4] = '{0, 0, 86, 34};

  hall_set_enumerator_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .restart        (restart),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .element_index  (element_index),
    .left_index     (left_index),
    .right_index    (right_index),
    .element_degree (element_degree),
    .status         (status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  hse_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .restart        (restart),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .element_index  (element_index),
    .left_index     (left_index),
    .right_index    (right_index),
    .element_degree (element_degree),
    .status         (status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .words_due      (words_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic rs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    restart  <= rs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic pick_config();
    logic [CFG_DATA_W-1:0] letters;
    logic [CFG_DATA_W-1:0] depth;
    letters = ($urandom_range(9) < 7) ? CFG_DATA_W'($urandom_range(1, 4))
                                      : CFG_DATA_W'($urandom_range(0, 31));
    depth = ($urandom_range(9) < 7) ? CFG_DATA_W'($urandom_range(2, 6))
                                    : CFG_DATA_W'($urandom_range(0, 31));
    if ($urandom_range(4) != 0) set_reg(CFG_ALPHABET_WIDTH, letters);
    if ($urandom_range(4) != 0) set_reg(CFG_MAX_DEGREE, depth);
  endtask

  task automatic enumeration_run(input int unsigned length);
    case ($urandom_range(5))
      0, 1: begin
        settle();
        pick_config();
      end
      2: settle();
      default: ;
    endcase
    send_word($urandom_range(7) != 0);
    for (int k = 0; k < length; k++) send_word($urandom_range(24) == 0);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int k = 0; k < 10; k++) send_word(1'b0);
    send_word(1'b1);
    send_word(1'b0);
    send_word(1'b1);

    settle();
    set_reg(CFG_ALPHABET_WIDTH, 5'd0);
    set_reg(CFG_MAX_DEGREE, 5'd2);
    send_word(1'b1);
    send_word(1'b0);

    settle();
    set_reg(CFG_ALPHABET_WIDTH, 5'd31);
    set_reg(CFG_MAX_DEGREE, 5'd0);
    send_word(1'b1);
    send_word(1'b0);
    send_word(1'b0);
    settle();
    set_reg(CFG_ALPHABET_WIDTH, 5'd3);
    send_word(1'b0);

    settle();
    set_reg(CFG_ALPHABET_WIDTH, 5'd1);
    set_reg(CFG_MAX_DEGREE, 5'd31);
    set_reg(CFG_SPARE_INDEX, 5'b10101);
    send_word(1'b1);
    send_word(1'b0);

    settle();
    set_reg(CFG_ALPHABET_WIDTH, 5'd2);
    set_reg(CFG_MAX_DEGREE, 5'd8);
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_plan[p];
      recv_stall_pct = stall_plan[p];
      while (words_sent < 25 + (p + 1) * (RANDOM_WORDS / 4))
        enumeration_run($urandom_range(5, 80));
    end

    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && words_due == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> hall_set_enumerator_top.f
hw/rtl/hse_pkg.sv
hw/rtl/hse_ctrl.sv
hw/rtl/hse_dp.sv
hw/rtl/hall_set_enumerator_top.sv
tb/hse_checker.sv
tb/tb.sv
